FILE: rtl/core/skl_pkg.sv
// skl_pkg: shared types, codes and field widths of the sorted key line table.
// Used by skl_mem, skl_seq and sorted_key_line_table_top; no dependencies.
`timescale 1ns / 1ps

package skl_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int OP_W      = 2;
    localparam int KEY_W     = 16;
    localparam int HANDLE_W  = 16;
    localparam int ENTRY_W   = KEY_W + HANDLE_W;
    localparam int STATUS_W  = 3;
    localparam int SLOT_W    = 6;
    localparam int CNT_W     = 7;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    localparam logic [OP_W-1:0] OP_STORE  = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_REPLACED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd5;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_SCAN,
        SQ_DECIDE,
        SQ_SHIFT_UP,
        SQ_SHIFT_DN,
        SQ_WRITE,
        SQ_DONE
    } t_seq_state;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [KEY_W-1:0]    line_key;
        logic [HANDLE_W-1:0] payload_handle;
    } t_item;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_index;
        logic [CNT_W-1:0]    entry_count;
    } t_result;

endpackage

FILE: rtl/core/skl_mem.sv
// skl_mem: entry store, one write port and one registered read port.
// Each word holds the key in the low bits and the payload handle above it.
`timescale 1ns / 1ps

module skl_mem #(
    parameter int DEPTH = skl_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [$clog2(DEPTH)-1:0]    i_waddr,
    input  logic [skl_pkg::ENTRY_W-1:0] i_wdata,
    input  logic [$clog2(DEPTH)-1:0]    i_raddr,
    output logic [skl_pkg::ENTRY_W-1:0] o_rdata
);

    logic [skl_pkg::ENTRY_W-1:0] r_mem [DEPTH];
    logic [skl_pkg::ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/skl_seq.sv
// skl_seq: sequencer with the shared key compare and index step unit.
// Scans the store, then shifts entries one per cycle; uses skl_pkg.
`timescale 1ns / 1ps

module skl_seq #(
    parameter int DEPTH = skl_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  skl_pkg::t_item              i_item,
    output logic                        o_idle,
    output skl_pkg::t_result            o_res,
    input  logic                        i_res_ready,
    output logic                        o_mem_we,
    output logic [$clog2(DEPTH)-1:0]    o_mem_waddr,
    output logic [skl_pkg::ENTRY_W-1:0] o_mem_wdata,
    output logic [$clog2(DEPTH)-1:0]    o_mem_raddr,
    input  logic [skl_pkg::ENTRY_W-1:0] i_mem_rdata
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    skl_pkg::t_seq_state              r_state, n_state;
    skl_pkg::t_item                   r_item, n_item;
    logic [CW-1:0]                    r_count, n_count;
    logic [IW-1:0]                    r_idx, n_idx;
    logic [CW-1:0]                    r_pos, n_pos;
    logic                             r_hit, n_hit;
    logic [skl_pkg::STATUS_W-1:0]     r_status, n_status;
    logic [skl_pkg::SLOT_W-1:0]       r_slot, n_slot;

    logic [skl_pkg::KEY_W-1:0]        w_rkey;
    logic [IW-1:0]                    w_pos_a;
    logic [skl_pkg::ENTRY_W-1:0]      w_new;

    assign w_rkey  = i_mem_rdata[skl_pkg::KEY_W-1:0];
    assign w_pos_a = r_pos[IW-1:0];
    assign w_new   = {r_item.payload_handle, r_item.line_key};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skl_pkg::SQ_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_hit    <= n_hit;
        r_status <= n_status;
        r_slot   <= n_slot;
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_hit       = r_hit;
        n_status    = r_status;
        n_slot      = r_slot;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_idx;
        o_mem_wdata = i_mem_rdata;
        o_mem_raddr = r_idx;
        unique case (r_state)
            skl_pkg::SQ_IDLE: begin
                if (i_start) begin
                    n_item      = i_item;
                    n_idx       = '0;
                    n_pos       = '0;
                    n_hit       = 1'b0;
                    o_mem_raddr = '0;
                    n_state     = (r_count == '0) ? skl_pkg::SQ_DECIDE : skl_pkg::SQ_SCAN;
                end
            end
            skl_pkg::SQ_SCAN: begin
                // sorted table: first key >= search key is the hit or the insert point
                if (w_rkey >= r_item.line_key) begin
                    n_pos   = CW'(r_idx);
                    n_hit   = (w_rkey == r_item.line_key);
                    n_state = skl_pkg::SQ_DECIDE;
                end else if (CW'(r_idx) + CW'(1) == r_count) begin
                    n_pos   = r_count;
                    n_hit   = 1'b0;
                    n_state = skl_pkg::SQ_DECIDE;
                end else begin
                    n_idx       = r_idx + IW'(1);
                    o_mem_raddr = r_idx + IW'(1);
                end
            end
            skl_pkg::SQ_DECIDE: begin
                n_status = skl_pkg::ST_NOT_FOUND;
                n_slot   = '0;
                n_state  = skl_pkg::SQ_DONE;
                case (r_item.op)
                    skl_pkg::OP_STORE: begin
                        if (r_hit) begin
                            o_mem_we    = 1'b1;
                            o_mem_waddr = w_pos_a;
                            o_mem_wdata = w_new;
                            n_status    = skl_pkg::ST_REPLACED;
                            n_slot      = skl_pkg::SLOT_W'(r_pos);
                        end else if (r_count >= CW'(DEPTH)) begin
                            n_status = skl_pkg::ST_FULL;
                        end else if (r_pos == r_count) begin
                            o_mem_we    = 1'b1;
                            o_mem_waddr = w_pos_a;
                            o_mem_wdata = w_new;
                            n_count     = r_count + CW'(1);
                            n_status    = skl_pkg::ST_INSERTED;
                            n_slot      = skl_pkg::SLOT_W'(r_pos);
                        end else begin
                            n_status    = skl_pkg::ST_INSERTED;
                            n_slot      = skl_pkg::SLOT_W'(r_pos);
                            n_idx       = IW'(r_count - CW'(1));
                            o_mem_raddr = IW'(r_count - CW'(1));
                            n_state     = skl_pkg::SQ_SHIFT_UP;
                        end
                    end
                    skl_pkg::OP_DELETE: begin
                        if (r_hit) begin
                            n_status = skl_pkg::ST_DELETED;
                            n_slot   = skl_pkg::SLOT_W'(r_pos);
                            if (r_pos + CW'(1) == r_count) begin
                                n_count = r_count - CW'(1);
                            end else begin
                                n_idx       = w_pos_a + IW'(1);
                                o_mem_raddr = w_pos_a + IW'(1);
                                n_state     = skl_pkg::SQ_SHIFT_DN;
                            end
                        end
                    end
                    skl_pkg::OP_FIND: begin
                        if (r_hit) begin
                            n_status = skl_pkg::ST_FOUND;
                            n_slot   = skl_pkg::SLOT_W'(r_pos);
                        end
                    end
                    default: begin
                        n_status = skl_pkg::ST_NOT_FOUND;
                    end
                endcase
            end
            skl_pkg::SQ_SHIFT_UP: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_idx + IW'(1);
                if (CW'(r_idx) == r_pos) begin
                    n_state = skl_pkg::SQ_WRITE;
                end else begin
                    n_idx       = r_idx - IW'(1);
                    o_mem_raddr = r_idx - IW'(1);
                end
            end
            skl_pkg::SQ_WRITE: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = w_pos_a;
                o_mem_wdata = w_new;
                n_count     = r_count + CW'(1);
                n_state     = skl_pkg::SQ_DONE;
            end
            skl_pkg::SQ_SHIFT_DN: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_idx - IW'(1);
                if (CW'(r_idx) + CW'(1) == r_count) begin
                    n_count = r_count - CW'(1);
                    n_state = skl_pkg::SQ_DONE;
                end else begin
                    n_idx       = r_idx + IW'(1);
                    o_mem_raddr = r_idx + IW'(1);
                end
            end
            skl_pkg::SQ_DONE: begin
                if (i_res_ready) begin
                    n_state = skl_pkg::SQ_IDLE;
                end
            end
            default: begin
                n_state = skl_pkg::SQ_IDLE;
            end
        endcase
    end

    assign o_idle            = (r_state == skl_pkg::SQ_IDLE);
    assign o_res.valid       = (r_state == skl_pkg::SQ_DONE);
    assign o_res.status      = r_status;
    assign o_res.slot_index  = r_slot;
    assign o_res.entry_count = skl_pkg::CNT_W'(r_count);

endmodule

FILE: rtl/core/sorted_key_line_table_top.sv
// sorted_key_line_table_top: sorted key table with stream ports.
// Instantiates skl_seq and skl_mem; uses skl_pkg.
//
// Usage: one item on the slave stream is a request: tuser carries the op
// (store, delete, find), tdata the line key (low half) and the payload
// handle (high half). Each request gives exactly one item on the master
// stream: tuser the status, tdata the slot index and the entry count.
// A request is worked as a linear scan over the single read port of the
// entry store (one entry per cycle), then for insert or delete one entry
// moved per cycle, then the result. tready is low while a request is in
// work. The result waits in an output register; the next request is taken
// while it waits, and a second result waits in the sequencer until the
// receiver takes the first. Reset (synchronous, active low) empties the
// table and the output stage; the entry store itself needs no clearing.
`timescale 1ns / 1ps

module sorted_key_line_table_top #(
    parameter int DEPTH = skl_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [skl_pkg::S_TDATA_W-1:0] i_s_axis_tdata,  // line_key, payload_handle
    input  logic [skl_pkg::OP_W-1:0]      i_s_axis_tuser,  // op
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [skl_pkg::M_TDATA_W-1:0] o_m_axis_tdata,  // slot_index, entry_count, zero pad
    output logic [skl_pkg::STATUS_W-1:0]  o_m_axis_tuser   // status
);

    localparam int IW = $clog2(DEPTH);

    skl_pkg::t_item                   w_item;
    skl_pkg::t_result                 w_res;
    logic                             w_idle;
    logic                             w_start;
    logic                             w_res_ready;
    logic                             w_mem_we;
    logic [IW-1:0]                    w_mem_waddr;
    logic [IW-1:0]                    w_mem_raddr;
    logic [skl_pkg::ENTRY_W-1:0]      w_mem_wdata;
    logic [skl_pkg::ENTRY_W-1:0]      w_mem_rdata;

    logic                             r_m_valid, n_m_valid;
    logic [skl_pkg::M_TDATA_W-1:0]    r_m_data, n_m_data;
    logic [skl_pkg::STATUS_W-1:0]     r_m_user, n_m_user;

    assign w_item.op             = i_s_axis_tuser;
    assign w_item.line_key       = i_s_axis_tdata[skl_pkg::KEY_W-1:0];
    assign w_item.payload_handle = i_s_axis_tdata[skl_pkg::ENTRY_W-1:skl_pkg::KEY_W];

    assign o_s_axis_tready = w_idle;
    assign w_start         = i_s_axis_tvalid && w_idle;
    assign w_res_ready     = !r_m_valid || i_m_axis_tready;

    skl_seq #(
        .DEPTH(DEPTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_item      (w_item),
        .o_idle      (w_idle),
        .o_res       (w_res),
        .i_res_ready (w_res_ready),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    skl_mem #(
        .DEPTH(DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    always_comb begin
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        n_m_user  = r_m_user;
        if (w_res.valid && w_res_ready) begin
            n_m_valid = 1'b1;
            n_m_data  = skl_pkg::M_TDATA_W'({w_res.entry_count, w_res.slot_index});
            n_m_user  = w_res.status;
        end else if (i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready
    ) else $error("sequencer idle right after taking an item");

    a_slot_zero_on_miss: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == skl_pkg::ST_FULL ||
                             o_m_axis_tuser == skl_pkg::ST_NOT_FOUND))
        |-> (o_m_axis_tdata[skl_pkg::SLOT_W-1:0] == '0)
    ) else $error("nonzero slot index on miss or full");

    a_result_held: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_res.valid && !w_res_ready) |=> (w_res.valid && $stable(w_res))
    ) else $error("pending result lost while output stage busy");

endmodule
